// ===== sv/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sitda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int DEC_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
  localparam int POS_W      = $clog2(DEC_DIGITS);
  localparam int ITER_W     = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // status of the shift-add-3 converter
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

// ===== sv/sitda_bcd.sv =====
// Iterative double-dabble converter: one shift-add-3 step per cycle.
`timescale 1ns / 1ps

module sitda_bcd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sitda_pkg::VALUE_W-1:0] mag,
  output logic [sitda_pkg::BCD_W-1:0]   bcd,
  output sitda_pkg::conv_stat_t         stat
);
  import sitda_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [ITER_W-1:0]  cnt;
  logic               busy;
  logic               done;
  logic [BCD_W-1:0]   adj;

  // add 3 to every BCD digit that is 5 or more before the shift
  always_comb begin
    adj = bcd;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= digit_t'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + digit_t'(3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ITER_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== sv/sitda_emit.sv =====
// Character sequencer: sign, then digits from the leading nonzero one, into an output register.
`timescale 1ns / 1ps

module sitda_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        neg,
  input  logic [sitda_pkg::BCD_W-1:0] bcd,
  output logic                        active,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [5:0] char_code, [7:6] zero
  output logic                        m_tlast
);
  import sitda_pkg::*;

  logic [BCD_W-1:0]  digits;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  lead;
  logic              sign_pend;
  logic              advance;
  logic [CHAR_W-1:0] char_code;
  digit_t            dig [DEC_DIGITS];

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      dig[i] = digits[i*DIGIT_W +: DIGIT_W];
    end
  end

  // highest nonzero digit of the fresh result; zero prints one digit
  always_comb begin
    lead = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        lead = POS_W'(i);
      end
    end
  end

  assign advance = active && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      sign_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load) begin
        active    <= 1'b1;
        sign_pend <= neg;
      end else if (advance) begin
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else if (pos == '0) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits <= bcd;
      pos    <= lead;
    end else if (advance && !sign_pend && pos != '0) begin
      pos <= pos - 1'b1;
    end
    if (advance) begin
      char_code <= sign_pend ? ASCII_MINUS : ASCII_ZERO + CHAR_W'(dig[pos]);
      m_tlast   <= !sign_pend && pos == '0;
    end
  end

  assign m_tdata = {2'b00, char_code};

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII character stream.
`timescale 1ns / 1ps

// Takes one 32-bit two's complement value per input transaction and sends its
// decimal text, most significant character first, one ASCII character per
// output transaction: a leading '-' for negative values, no leading zeros,
// a lone '0' for zero, -2147483648 spelled in full. tlast marks the final
// character. The magnitude goes through a double-dabble unit that handles one
// bit per cycle and runs 32 shift-add-3 steps per value before its characters
// are sent. The next value is taken once the last character of the current
// one sits in the output register.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [5:0] char_code, [7:6] zero
  output logic        m_tlast     // last_char
);
  import sitda_pkg::*;

  state_t             state;
  state_t             state_next;
  logic               neg;
  logic               start;
  logic               emit_load;
  logic               emit_active;
  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  conv_stat_t         conv_stat;

  assign mag = s_tdata[VALUE_W-1] ? ~s_tdata + 1'b1 : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= s_tdata[VALUE_W-1];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_CONV;
      ST_CONV: if (conv_stat.done) state_next = ST_EMIT;
      ST_EMIT: if (!emit_active) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    start     = 1'b0;
    emit_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        start    = s_tvalid;
      end
      ST_CONV: emit_load = conv_stat.done;
      ST_EMIT: ;
      default: ;
    endcase
  end

  sitda_bcd u_bcd (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mag  (mag),
    .bcd  (bcd),
    .stat (conv_stat)
  );

  sitda_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (emit_load),
    .neg     (neg),
    .bcd     (bcd),
    .active  (emit_active),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

`ifndef SYNTHESIS
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_CONV && conv_stat.busy))
    else $error("accepted value did not start a conversion");

  a_done_only_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_stat.done |-> (state == ST_CONV))
    else $error("conversion finished outside the conversion state");

  a_idle_emitter_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!emit_active && !conv_stat.busy))
    else $error("ready while a number is still in flight");

  a_busy_ends_in_done: assert property (@(posedge clk) disable iff (rst)
    $fell(conv_stat.busy) |-> conv_stat.done)
    else $error("conversion stopped without completion");
`endif

endmodule
